### sv/swtq_pkg.sv
package swtq_pkg;

	// field widths
	localparam int OP_W    = 2;
	localparam int ID_W    = 16;
	localparam int TICK_W  = 48;
	localparam int ST_W    = 3;
	localparam int ENTRY_W = ID_W + TICK_W;

	// defaults and limits
	localparam int QUEUE_DEPTH_DEF = 32;
	localparam int MAX_RESULTS     = 32;

	// opcodes
	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

	// result status codes
	localparam logic [ST_W-1:0] ST_WOKEN       = 3'd0;
	localparam logic [ST_W-1:0] ST_QUEUED      = 3'd1;
	localparam logic [ST_W-1:0] ST_ALREADY_DUE = 3'd2;
	localparam logic [ST_W-1:0] ST_FULL        = 3'd3;
	localparam logic [ST_W-1:0] ST_REMOVED     = 3'd4;
	localparam logic [ST_W-1:0] ST_NOT_FOUND   = 3'd5;
	localparam logic [ST_W-1:0] ST_NOTHING_DUE = 3'd6;

	// read address select, relative to the scan index
	localparam logic [1:0] RD_AT_IDX = 2'd0;
	localparam logic [1:0] RD_BELOW  = 2'd1;
	localparam logic [1:0] RD_ABOVE  = 2'd2;

	// write data select
	localparam logic WR_NEW  = 1'b0;
	localparam logic WR_MOVE = 1'b1;

	// output id select
	localparam logic [1:0] ID_REQ  = 2'd0;
	localparam logic [1:0] ID_ZERO = 2'd1;
	localparam logic [1:0] ID_RD   = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic            cap_req;
		logic            idx_clr;
		logic            idx_load_cnt;
		logic            idx_inc;
		logic            idx_dec;
		logic            rd_en;
		logic [1:0]      rd_sel;
		logic            wr_en;
		logic            wr_sel;
		logic            cnt_inc;
		logic            cnt_dec;
		logic            pops_save;
		logic            pop_commit;
		logic            out_load;
		logic [ST_W-1:0] out_status;
		logic [1:0]      out_id_sel;
		logic            out_last;
	} swtq_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            cnt_zero;
		logic            full;
		logic            ins_due;
		logic            idx_zero;
		logic            idx_one;
		logic            idx_last;
		logic            idx_lim;
		logic            rd_after;
		logic            rd_match;
		logic            rd_due;
		logic            out_free;
	} swtq_sts_t;

endpackage

### sv/sorted_wakeup_timer_queue_unit.sv
// channel  direction  handshake            payload
// in       into       in_valid / in_stall  opcode, thread_id, wake_time, now
// out      out of     out_valid / out_stall status, woken_id, last
//
// one request at a time; entries sit in a ring in one memory with a registered
// read port, so each entry visited takes a read, then a compare or move.
// insert moves later entries up one by one before it writes the new entry;
// remove searches forward, then moves the entries behind the match down;
// tick checks entries from the head, then emits one result per woken id.
// reset clears head, count, scan index, pop count, state and result valid,
// not the stored entries.
// in_stall is high while busy; out_stall holds the result register, and the
// sequencer waits in its output states until that register frees.
module sorted_wakeup_timer_queue_unit #(
	parameter int QUEUE_DEPTH = swtq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [swtq_pkg::OP_W-1:0]   opcode,
	input  logic [swtq_pkg::ID_W-1:0]   thread_id,
	input  logic [swtq_pkg::TICK_W-1:0] wake_time,
	input  logic [swtq_pkg::TICK_W-1:0] now,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [swtq_pkg::ST_W-1:0]   status,
	output logic [swtq_pkg::ID_W-1:0]   woken_id,
	output logic                        last
);

	swtq_pkg::swtq_cmd_t cmd;
	swtq_pkg::swtq_sts_t sts;
	logic                busy;

	// sequencer
	swtq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.sts     (sts),
		.cmd     (cmd),
		.busy    (busy)
	);

	// queue store and result register
	swtq_dp #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.opcode   (opcode),
		.thread_id(thread_id),
		.wake_time(wake_time),
		.now      (now),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.status   (status),
		.woken_id (woken_id),
		.last     (last),
		.cmd      (cmd),
		.sts      (sts)
	);

	assign in_stall = busy;

`ifndef ASSERT_OFF
	// a result is never loaded over one still waiting
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result register overwritten");

	// no insert grows a full queue
	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_inc |-> !sts.full)
		else $error("insert into full queue");

	// an accepted request makes the block busy next cycle
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("request accepted without going busy");

	// popped entries retire only with the final woken result
	a_pop_with_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop_commit |-> (cmd.out_load && cmd.out_last))
		else $error("pop committed without final result");
`endif

endmodule

### sv/swtq_ram.sv
module swtq_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### sv/swtq_ctrl.sv
module swtq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  swtq_pkg::swtq_sts_t sts,
	output swtq_pkg::swtq_cmd_t cmd,
	output logic                busy
);

	localparam logic [3:0] S_IDLE      = 4'd0;
	localparam logic [3:0] S_DECODE    = 4'd1;
	localparam logic [3:0] S_RESP      = 4'd2;
	localparam logic [3:0] S_INS_RD    = 4'd3;
	localparam logic [3:0] S_INS_CMP   = 4'd4;
	localparam logic [3:0] S_REM_RD    = 4'd5;
	localparam logic [3:0] S_REM_CMP   = 4'd6;
	localparam logic [3:0] S_REM_SRD   = 4'd7;
	localparam logic [3:0] S_REM_SWR   = 4'd8;
	localparam logic [3:0] S_TICK_RD   = 4'd9;
	localparam logic [3:0] S_TICK_CMP  = 4'd10;
	localparam logic [3:0] S_TICK_ERD  = 4'd11;
	localparam logic [3:0] S_TICK_EOUT = 4'd12;

	logic [3:0]                state_q, state_d;
	logic [swtq_pkg::ST_W-1:0] res_q, res_d;

	// state and pending single result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_q   <= swtq_pkg::ST_QUEUED;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	// next state and commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		res_d   = res_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.cap_req = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				case (sts.op)
					swtq_pkg::OP_INSERT: begin
						if (sts.ins_due) begin
							res_d   = swtq_pkg::ST_ALREADY_DUE;
							state_d = S_RESP;
						end else if (sts.full) begin
							res_d   = swtq_pkg::ST_FULL;
							state_d = S_RESP;
						end else begin
							cmd.idx_load_cnt = 1'b1;
							state_d          = S_INS_RD;
						end
					end
					swtq_pkg::OP_REMOVE: begin
						if (sts.cnt_zero) begin
							res_d   = swtq_pkg::ST_NOT_FOUND;
							state_d = S_RESP;
						end else begin
							cmd.idx_clr = 1'b1;
							state_d     = S_REM_RD;
						end
					end
					swtq_pkg::OP_TICK: begin
						if (sts.cnt_zero) begin
							res_d   = swtq_pkg::ST_NOTHING_DUE;
							state_d = S_RESP;
						end else begin
							cmd.idx_clr = 1'b1;
							state_d     = S_TICK_RD;
						end
					end
					default: begin
						// unused opcode: no result
						state_d = S_IDLE;
					end
				endcase
			end
			S_RESP: begin
				if (sts.out_free) begin
					cmd.out_load   = 1'b1;
					cmd.out_status = res_q;
					cmd.out_id_sel = (res_q == swtq_pkg::ST_NOTHING_DUE) ?
						swtq_pkg::ID_ZERO : swtq_pkg::ID_REQ;
					cmd.out_last   = 1'b1;
					state_d        = S_IDLE;
				end
			end
			// insert: walk back from the tail, moving later entries up
			S_INS_RD: begin
				if (sts.idx_zero) begin
					cmd.wr_en   = 1'b1;
					cmd.wr_sel  = swtq_pkg::WR_NEW;
					cmd.cnt_inc = 1'b1;
					res_d       = swtq_pkg::ST_QUEUED;
					state_d     = S_RESP;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = swtq_pkg::RD_BELOW;
					state_d    = S_INS_CMP;
				end
			end
			S_INS_CMP: begin
				cmd.wr_en = 1'b1;
				if (sts.rd_after) begin
					cmd.wr_sel  = swtq_pkg::WR_MOVE;
					cmd.idx_dec = 1'b1;
					state_d     = S_INS_RD;
				end else begin
					cmd.wr_sel  = swtq_pkg::WR_NEW;
					cmd.cnt_inc = 1'b1;
					res_d       = swtq_pkg::ST_QUEUED;
					state_d     = S_RESP;
				end
			end
			// remove: search forward, then close the gap
			S_REM_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = swtq_pkg::RD_AT_IDX;
				state_d    = S_REM_CMP;
			end
			S_REM_CMP: begin
				if (sts.rd_match) begin
					state_d = S_REM_SRD;
				end else if (sts.idx_last) begin
					res_d   = swtq_pkg::ST_NOT_FOUND;
					state_d = S_RESP;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = S_REM_RD;
				end
			end
			S_REM_SRD: begin
				if (sts.idx_last) begin
					cmd.cnt_dec = 1'b1;
					res_d       = swtq_pkg::ST_REMOVED;
					state_d     = S_RESP;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = swtq_pkg::RD_ABOVE;
					state_d    = S_REM_SWR;
				end
			end
			S_REM_SWR: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = swtq_pkg::WR_MOVE;
				cmd.idx_inc = 1'b1;
				state_d     = S_REM_SRD;
			end
			// tick: count due entries from the head
			S_TICK_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = swtq_pkg::RD_AT_IDX;
				state_d    = S_TICK_CMP;
			end
			S_TICK_CMP: begin
				if (sts.rd_due) begin
					cmd.idx_inc = 1'b1;
					if (sts.idx_last || sts.idx_lim) begin
						cmd.pops_save = 1'b1;
						state_d       = S_TICK_ERD;
					end else begin
						state_d = S_TICK_RD;
					end
				end else if (sts.idx_zero) begin
					res_d   = swtq_pkg::ST_NOTHING_DUE;
					state_d = S_RESP;
				end else begin
					cmd.pops_save = 1'b1;
					state_d       = S_TICK_ERD;
				end
			end
			// tick: emit popped ids, latest first
			S_TICK_ERD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = swtq_pkg::RD_BELOW;
				state_d    = S_TICK_EOUT;
			end
			S_TICK_EOUT: begin
				if (sts.out_free) begin
					cmd.out_load   = 1'b1;
					cmd.out_status = swtq_pkg::ST_WOKEN;
					cmd.out_id_sel = swtq_pkg::ID_RD;
					cmd.out_last   = sts.idx_one;
					cmd.idx_dec    = 1'b1;
					if (sts.idx_one) begin
						cmd.pop_commit = 1'b1;
						state_d        = S_IDLE;
					end else begin
						state_d = S_TICK_ERD;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

### sv/swtq_dp.sv
module swtq_dp #(
	parameter int QUEUE_DEPTH = swtq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [swtq_pkg::OP_W-1:0]     opcode,
	input  logic [swtq_pkg::ID_W-1:0]     thread_id,
	input  logic [swtq_pkg::TICK_W-1:0]   wake_time,
	input  logic [swtq_pkg::TICK_W-1:0]   now,
	input  logic                          out_stall,
	output logic                          out_valid,
	output logic [swtq_pkg::ST_W-1:0]     status,
	output logic [swtq_pkg::ID_W-1:0]     woken_id,
	output logic                          last,
	input  swtq_pkg::swtq_cmd_t           cmd,
	output swtq_pkg::swtq_sts_t           sts
);

	localparam int AW   = $clog2(QUEUE_DEPTH);
	localparam int RD   = 1 << AW;
	localparam int CW   = $clog2(QUEUE_DEPTH + 1);
	localparam int LIMV = (swtq_pkg::MAX_RESULTS < QUEUE_DEPTH) ?
		swtq_pkg::MAX_RESULTS : QUEUE_DEPTH;
	localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);
	localparam logic [CW:0]   POP_LIM  = (CW + 1)'(LIMV);

	// request registers
	logic [swtq_pkg::OP_W-1:0]   op_q;
	logic [swtq_pkg::ID_W-1:0]   id_q;
	logic [swtq_pkg::TICK_W-1:0] wake_q;
	logic [swtq_pkg::TICK_W-1:0] now_q;

	// queue bookkeeping
	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q, idx_d;
	logic [CW-1:0] pops_q;

	// memory ports
	logic                           wr_en;
	logic [AW-1:0]                  wr_addr;
	logic [swtq_pkg::ENTRY_W-1:0]   wr_data;
	logic [AW-1:0]                  rd_addr;
	logic [swtq_pkg::ENTRY_W-1:0]   rd_data;
	logic [swtq_pkg::ID_W-1:0]      rd_id;
	logic [swtq_pkg::TICK_W-1:0]    rd_wake;
	logic [AW-1:0]                  idx_addr;

	// output register
	logic                        out_valid_q;
	logic [swtq_pkg::ST_W-1:0]   status_q;
	logic [swtq_pkg::ID_W-1:0]   woken_id_q;
	logic                        last_q;
	logic [swtq_pkg::ID_W-1:0]   out_id;

	// capture the request
	always_ff @(posedge clk) begin
		if (cmd.cap_req) begin
			op_q   <= opcode;
			id_q   <= thread_id;
			wake_q <= wake_time;
			now_q  <= now;
		end
	end

	// next scan index
	always_comb begin
		if (cmd.idx_clr) begin
			idx_d = '0;
		end else if (cmd.idx_load_cnt) begin
			idx_d = count_q;
		end else if (cmd.idx_inc) begin
			idx_d = idx_q + CW'(1);
		end else if (cmd.idx_dec) begin
			idx_d = idx_q - CW'(1);
		end else begin
			idx_d = idx_q;
		end
	end

	// head, count, index and pop count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			idx_q   <= '0;
			pops_q  <= '0;
		end else begin
			idx_q <= idx_d;
			if (cmd.pops_save) begin
				pops_q <= idx_d;
			end
			if (cmd.pop_commit) begin
				head_q  <= head_q + pops_q[AW-1:0];
				count_q <= count_q - pops_q;
			end else if (cmd.cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// ring addressing from the head
	assign idx_addr = head_q + idx_q[AW-1:0];

	always_comb begin
		case (cmd.rd_sel)
			swtq_pkg::RD_AT_IDX: rd_addr = idx_addr;
			swtq_pkg::RD_BELOW:  rd_addr = idx_addr - AW'(1);
			swtq_pkg::RD_ABOVE:  rd_addr = idx_addr + AW'(1);
			default:             rd_addr = idx_addr;
		endcase
	end

	assign wr_en   = cmd.wr_en;
	assign wr_addr = idx_addr;
	assign wr_data = (cmd.wr_sel == swtq_pkg::WR_MOVE) ? rd_data : {id_q, wake_q};

	swtq_ram #(
		.WIDTH(swtq_pkg::ENTRY_W),
		.DEPTH(RD)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (cmd.rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign rd_id   = rd_data[swtq_pkg::ENTRY_W-1:swtq_pkg::TICK_W];
	assign rd_wake = rd_data[swtq_pkg::TICK_W-1:0];

	// status flags
	assign sts.op       = op_q;
	assign sts.cnt_zero = (count_q == '0);
	assign sts.full     = (count_q == CNT_FULL);
	assign sts.ins_due  = (wake_q <= now_q);
	assign sts.idx_zero = (idx_q == '0);
	assign sts.idx_one  = (idx_q == CW'(1));
	assign sts.idx_last = (({1'b0, idx_q} + (CW + 1)'(1)) == {1'b0, count_q});
	assign sts.idx_lim  = (({1'b0, idx_q} + (CW + 1)'(1)) == POP_LIM);
	assign sts.rd_after = (rd_wake > wake_q);
	assign sts.rd_match = (rd_id == id_q);
	assign sts.rd_due   = (rd_wake <= now_q);
	assign sts.out_free = !out_valid_q || !out_stall;

	// result id select
	always_comb begin
		case (cmd.out_id_sel)
			swtq_pkg::ID_REQ:  out_id = id_q;
			swtq_pkg::ID_ZERO: out_id = '0;
			swtq_pkg::ID_RD:   out_id = rd_id;
			default:           out_id = id_q;
		endcase
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			status_q   <= cmd.out_status;
			woken_id_q <= out_id;
			last_q     <= cmd.out_last;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign woken_id  = woken_id_q;
	assign last      = last_q;

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import swtq_pkg::*;

	localparam int DEPTH       = QUEUE_DEPTH_DEF;
	localparam int ITEM_TARGET = 330;
	localparam int IDLE_LIMIT  = 4000;
	localparam int SETTLE      = 300;
	localparam int PRINT_CAP   = 100;
	localparam int POOL_N      = 12;

	localparam logic [OP_W-1:0]   OP_UNUSED = 2'd3;
	localparam logic [TICK_W-1:0] TICK_MAX  = {TICK_W{1'b1}};
	localparam logic [ID_W-1:0]   ID_MAX    = {ID_W{1'b1}};

	typedef struct {
		logic [OP_W-1:0]   op;
		logic [ID_W-1:0]   id;
		logic [TICK_W-1:0] wake;
		logic [TICK_W-1:0] at;
		bit                drain_first;
	} sleep_req_t;

	typedef struct packed {
		logic [ST_W-1:0] status;
		logic [ID_W-1:0] id;
		logic            last;
	} outcome_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [OP_W-1:0]   opcode = '0;
	logic [ID_W-1:0]   thread_id = '0;
	logic [TICK_W-1:0] wake_time = '0;
	logic [TICK_W-1:0] now = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [ST_W-1:0]   status;
	logic [ID_W-1:0]   woken_id;
	logic              last;

	// shadow of the sleeper list
	logic [ID_W-1:0]   sleeper_id [DEPTH];
	logic [TICK_W-1:0] sleeper_wake [DEPTH];
	int                sleeper_count = 0;

	sleep_req_t pending_reqs[$];
	outcome_t   queued_outcomes[$];

	int send_gap = 0;
	int hold_gap = 0;
	int sent_count = 0;
	int result_count = 0;
	int fail_count = 0;
	int idle_cycles = 0;
	int status_seen [8];

	sorted_wakeup_timer_queue_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.thread_id (thread_id),
		.wake_time (wake_time),
		.now       (now),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.woken_id  (woken_id),
		.last      (last)
	);

	// clock
	initial begin
		forever #4 clk = ~clk;
	end

	// random gap length, none inside the steady window
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (sent_count >= 150 && sent_count < 200)
			return 0;
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void note_outcome(logic [ST_W-1:0] st, logic [ID_W-1:0] id, logic lst);
		outcome_t o;
		o.status = st;
		o.id     = id;
		o.last   = lst;
		queued_outcomes.push_back(o);
	endfunction

	// apply one request to the shadow list and queue the results it causes
	function automatic void timer_queue_step(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
			logic [TICK_W-1:0] wake, logic [TICK_W-1:0] t_now);
		int pos;
		int pops;
		int i;
		case (op)
		OP_INSERT: begin
			if (wake <= t_now) begin
				note_outcome(ST_ALREADY_DUE, id, 1'b1);
			end else if (sleeper_count >= DEPTH) begin
				note_outcome(ST_FULL, id, 1'b1);
			end else begin
				// equal ticks keep arrival order
				pos = 0;
				while (pos < sleeper_count && sleeper_wake[pos] <= wake)
					pos++;
				for (i = sleeper_count; i > pos; i--) begin
					sleeper_id[i]   = sleeper_id[i-1];
					sleeper_wake[i] = sleeper_wake[i-1];
				end
				sleeper_id[pos]   = id;
				sleeper_wake[pos] = wake;
				sleeper_count++;
				note_outcome(ST_QUEUED, id, 1'b1);
			end
		end
		OP_REMOVE: begin
			pos = 0;
			while (pos < sleeper_count && sleeper_id[pos] != id)
				pos++;
			if (pos >= sleeper_count) begin
				note_outcome(ST_NOT_FOUND, id, 1'b1);
			end else begin
				for (i = pos; i + 1 < sleeper_count; i++) begin
					sleeper_id[i]   = sleeper_id[i+1];
					sleeper_wake[i] = sleeper_wake[i+1];
				end
				sleeper_count--;
				note_outcome(ST_REMOVED, id, 1'b1);
			end
		end
		OP_TICK: begin
			pops = 0;
			while (pops < sleeper_count && pops < MAX_RESULTS && sleeper_wake[pops] <= t_now)
				pops++;
			if (pops == 0) begin
				note_outcome(ST_NOTHING_DUE, '0, 1'b1);
			end else begin
				// most recently popped comes out first
				for (i = 0; i < pops; i++)
					note_outcome(ST_WOKEN, sleeper_id[pops-1-i], i + 1 == pops);
				for (i = 0; i + pops < sleeper_count; i++) begin
					sleeper_id[i]   = sleeper_id[i+pops];
					sleeper_wake[i] = sleeper_wake[i+pops];
				end
				sleeper_count -= pops;
			end
		end
		default: begin
		end
		endcase
	endfunction

	function automatic void flag_mismatch(string field, longint want, longint got);
		fail_count++;
		if (fail_count <= PRINT_CAP)
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin : drive_requests
		sleep_req_t cur;
		if (!arst_n) begin
			in_valid  <= 1'b0;
			opcode    <= '0;
			thread_id <= '0;
			wake_time <= '0;
			now       <= '0;
			send_gap = 0;
		end else begin
			if (in_valid && !in_stall) begin
				timer_queue_step(opcode, thread_id, wake_time, now);
				sent_count++;
				send_gap = pick_gap();
			end
			if (in_valid && in_stall) begin
				// hold the stalled request
			end else if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (pending_reqs.size() != 0 &&
					!(pending_reqs[0].drain_first && queued_outcomes.size() != 0)) begin
				cur = pending_reqs.pop_front();
				opcode    <= cur.op;
				thread_id <= cur.id;
				wake_time <= cur.wake;
				now       <= cur.at;
				in_valid  <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result monitor and stall generator
	always @(posedge clk or negedge arst_n) begin : watch_results
		outcome_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_gap = 0;
		end else begin
			if (out_valid && !out_stall) begin
				result_count++;
				status_seen[status]++;
				if (queued_outcomes.size() == 0) begin
					fail_count++;
					if (fail_count <= PRINT_CAP)
						$display("%0t: unexpected result, expected none, actual status %0d id %0d",
							$time, status, woken_id);
				end else begin
					want = queued_outcomes.pop_front();
					if (status !== want.status)
						flag_mismatch("status", want.status, status);
					if (woken_id !== want.id)
						flag_mismatch("woken_id", want.id, woken_id);
					if (last !== want.last)
						flag_mismatch("last", want.last, last);
				end
			end
			if (hold_gap > 0) begin
				hold_gap--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				hold_gap = pick_gap();
			end
		end
	end

	// watchdog on handshake activity
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
				$display("testbench: errors");
				$finish;
			end
		end
	end

	task automatic add_req(logic [OP_W-1:0] op, logic [ID_W-1:0] id, logic [TICK_W-1:0] wake,
			logic [TICK_W-1:0] at, bit drain_first);
		sleep_req_t r;
		r.op          = op;
		r.id          = id;
		r.wake        = wake;
		r.at          = at;
		r.drain_first = drain_first;
		pending_reqs.push_back(r);
	endtask

	// stimulus, run control and final verdict
	initial begin : run_control
		logic [ID_W-1:0]   id_pool [POOL_N];
		logic [TICK_W-1:0] gen_now;
		int planned;
		int pick;
		int j;
		bit first_burst;

		for (j = 0; j < POOL_N; j++)
			id_pool[j] = ID_W'($urandom_range(0, ID_MAX));
		id_pool[0] = '0;
		id_pool[1] = ID_MAX;

		// directed: empty queue, boundary ticks, equal ticks, duplicate ids
		add_req(OP_TICK, 16'h0000, '0, '0, 1'b0);
		add_req(OP_REMOVE, 16'h0000, '0, '0, 1'b0);
		add_req(OP_INSERT, 16'h0000, TICK_MAX, TICK_MAX, 1'b0);
		add_req(OP_INSERT, ID_MAX, '0, '0, 1'b0);
		add_req(OP_INSERT, ID_MAX, TICK_MAX, TICK_MAX - TICK_W'(1), 1'b0);
		add_req(OP_INSERT, 16'h0001, 48'd10, '0, 1'b0);
		add_req(OP_INSERT, 16'h0002, 48'd10, 48'd5, 1'b0);
		add_req(OP_INSERT, 16'h0001, 48'd5, '0, 1'b0);
		add_req(OP_INSERT, 16'h0003, 48'd10, 48'd9, 1'b0);
		add_req(OP_UNUSED, 16'hA5A5, 48'hAAAA_5555_AAAA, 48'h5555_AAAA_5555, 1'b0);
		add_req(OP_REMOVE, 16'h0001, '0, '0, 1'b0);
		add_req(OP_REMOVE, 16'h1234, '0, '0, 1'b0);
		add_req(OP_TICK, 16'hFFFF, TICK_MAX, 48'd4, 1'b0);
		add_req(OP_TICK, 16'h0000, '0, 48'd10, 1'b0);
		add_req(OP_TICK, 16'h0000, '0, TICK_MAX, 1'b0);
		add_req(OP_TICK, 16'h0000, '0, TICK_MAX, 1'b0);
		planned = 15;

		// random traffic on a moving time base with some noise
		gen_now = {16'($urandom_range(0, 16'hFFFE)), 32'($urandom())};
		first_burst = 1'b1;
		while (planned < ITEM_TARGET) begin
			pick = $urandom_range(0, 99);
			if (first_burst || pick < 4) begin
				// fill the store past full, then wake a full batch
				for (j = 0; j < DEPTH + 2; j++)
					add_req(OP_INSERT, id_pool[$urandom_range(0, POOL_N-1)],
						gen_now + TICK_W'(1000 + $urandom_range(0, 50)), gen_now,
						first_burst && j == 0);
				gen_now += TICK_W'(5000);
				add_req(OP_TICK, ID_W'($urandom_range(0, ID_MAX)), TICK_W'($urandom()),
					gen_now, 1'b0);
				planned += DEPTH + 3;
				first_burst = 1'b0;
			end else if (pick < 50) begin
				add_req(OP_INSERT, id_pool[$urandom_range(0, POOL_N-1)],
					gen_now + TICK_W'($urandom_range(0, 50)), gen_now, 1'b0);
				planned++;
			end else if (pick < 65) begin
				add_req(OP_REMOVE, id_pool[$urandom_range(0, POOL_N-1)],
					{16'($urandom()), 32'($urandom())}, gen_now, 1'b0);
				planned++;
			end else if (pick < 90) begin
				gen_now += TICK_W'($urandom_range(0, 20));
				add_req(OP_TICK, ID_W'($urandom_range(0, ID_MAX)),
					{16'($urandom()), 32'($urandom())},
					gen_now, planned >= 200 && planned < 202);
				planned++;
			end else begin
				// noise over the full field ranges
				add_req(OP_W'($urandom_range(0, 3)), ID_W'($urandom_range(0, ID_MAX)),
					{16'($urandom()), 32'($urandom())}, {16'($urandom()), 32'($urandom())}, 1'b0);
				if (pending_reqs[$].op != OP_UNUSED)
					planned++;
			end
		end
		add_req(OP_TICK, 16'h0000, '0, TICK_MAX, 1'b1);

		// reset
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// wait for the stimulus to go in and every result to come out
		while (pending_reqs.size() != 0 || in_valid)
			@(negedge clk);
		while (queued_outcomes.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);

		$display("covered %0d requests and %0d results", sent_count, result_count);
		$write("woken %0d, queued %0d, already_due %0d, full %0d, ",
			status_seen[ST_WOKEN], status_seen[ST_QUEUED], status_seen[ST_ALREADY_DUE],
			status_seen[ST_FULL]);
		$display("removed %0d, not_found %0d, nothing_due %0d",
			status_seen[ST_REMOVED], status_seen[ST_NOT_FOUND], status_seen[ST_NOTHING_DUE]);
		if (fail_count == 0 && queued_outcomes.size() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
